// ===== hw/rtl/biq_pkg.sv =====
package biq_pkg;

  // default widths
  localparam int SAMPLE_WIDTH_DEF   = 24;
  localparam int STATE_WIDTH_DEF    = 32;
  localparam int COEF_FRAC_BITS_DEF = 16;

  // configuration port
  localparam int CFG_DATA_WIDTH = 32;
  localparam int CFG_ADDR_WIDTH = 4;
  localparam int REG_IDX_WIDTH  = 2;

  typedef logic [REG_IDX_WIDTH-1:0] reg_idx_t;

  localparam reg_idx_t REG_FB_COEF_1 = 2'd0;
  localparam reg_idx_t REG_FB_COEF_2 = 2'd1;
  localparam reg_idx_t REG_FF_COEF_1 = 2'd2;
  localparam reg_idx_t REG_FF_COEF_2 = 2'd3;

endpackage

// ===== hw/rtl/biquad_iir_filter.sv =====
// channel   | handshake           | payload
// ----------+---------------------+------------------------------------------
// input     | in_valid / in_stall | sample_in, frame_end
// output    | out_valid/out_stall | sample_out, frame_end_out, saturated
// config    | apb psel/penable    | paddr 4*i: fb_coef_1, fb_coef_2, ff_coef_1, ff_coef_2
//
// one sample per cycle sustained while the output is not stalled; a sample passes
// through the input register, state update stage and output register
// the feedback loop is two parallel multiplies, a three-input add and a clamp per cycle
// rst is synchronous and clears the delays, coefficients and all stage valids
// a stall on the output backs up through the stages; in_stall rises only when
// every stage holds a sample
module biquad_iir_filter #(
  parameter int SAMPLE_WIDTH   = biq_pkg::SAMPLE_WIDTH_DEF,
  parameter int STATE_WIDTH    = biq_pkg::STATE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = biq_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]       sample_in,
  input  logic                                 frame_end,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]       sample_out,
  output logic                                 frame_end_out,
  output logic                                 saturated,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [biq_pkg::CFG_ADDR_WIDTH-1:0]   paddr,
  input  logic [biq_pkg::CFG_DATA_WIDTH-1:0]   pwdata,
  output logic [biq_pkg::CFG_DATA_WIDTH-1:0]   prdata,
  output logic                                 pready
);

  localparam int CW   = COEF_FRAC_BITS + 2;
  localparam int PW   = STATE_WIDTH + CW;
  localparam int TW2  = STATE_WIDTH + 2;
  localparam int SUMW = ((SAMPLE_WIDTH > TW2) ? SAMPLE_WIDTH : TW2) + 2;
  localparam int DW   = biq_pkg::CFG_DATA_WIDTH;

  localparam logic signed [CW-1:0] COEF_ONE     = {2'b01, {COEF_FRAC_BITS{1'b0}}};
  localparam logic signed [CW-1:0] COEF_NEG_ONE = {2'b11, {COEF_FRAC_BITS{1'b0}}};
  localparam logic signed [SUMW-1:0] W_MAX =
    {{(SUMW-STATE_WIDTH+1){1'b0}}, {(STATE_WIDTH-1){1'b1}}};
  localparam logic signed [SUMW-1:0] W_MIN =
    {{(SUMW-STATE_WIDTH+1){1'b1}}, {(STATE_WIDTH-1){1'b0}}};
  localparam logic signed [SUMW-1:0] Y_MAX =
    {{(SUMW-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SUMW-1:0] Y_MIN =
    {{(SUMW-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

  // configuration registers
  logic signed [CW-1:0] fb_coef_1, fb_coef_2, ff_coef_1, ff_coef_2;
  biq_pkg::reg_idx_t    reg_idx;
  logic                 cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[biq_pkg::CFG_ADDR_WIDTH-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fb_coef_1 <= '0;
      fb_coef_2 <= '0;
      ff_coef_1 <= '0;
      ff_coef_2 <= '0;
    end else if (cfg_write) begin
      unique case (reg_idx)
        biq_pkg::REG_FB_COEF_1: fb_coef_1 <= pwdata[CW-1:0];
        biq_pkg::REG_FB_COEF_2: fb_coef_2 <= pwdata[CW-1:0];
        biq_pkg::REG_FF_COEF_1: ff_coef_1 <= pwdata[CW-1:0];
        biq_pkg::REG_FF_COEF_2: ff_coef_2 <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      biq_pkg::REG_FB_COEF_1: prdata = DW'(fb_coef_1);
      biq_pkg::REG_FB_COEF_2: prdata = DW'(fb_coef_2);
      biq_pkg::REG_FF_COEF_1: prdata = DW'(ff_coef_1);
      biq_pkg::REG_FF_COEF_2: prdata = DW'(ff_coef_2);
      default:                prdata = '0;
    endcase
  end

  // coefficients limited to plus or minus one
  logic signed [CW-1:0] fb1_c, fb2_c, ff1_c, ff2_c;

  always_comb begin
    fb1_c = fb_coef_1;
    if (fb_coef_1 > COEF_ONE) fb1_c = COEF_ONE;
    else if (fb_coef_1 < COEF_NEG_ONE) fb1_c = COEF_NEG_ONE;
    fb2_c = fb_coef_2;
    if (fb_coef_2 > COEF_ONE) fb2_c = COEF_ONE;
    else if (fb_coef_2 < COEF_NEG_ONE) fb2_c = COEF_NEG_ONE;
    ff1_c = ff_coef_1;
    if (ff_coef_1 > COEF_ONE) ff1_c = COEF_ONE;
    else if (ff_coef_1 < COEF_NEG_ONE) ff1_c = COEF_NEG_ONE;
    ff2_c = ff_coef_2;
    if (ff_coef_2 > COEF_ONE) ff2_c = COEF_ONE;
    else if (ff_coef_2 < COEF_NEG_ONE) ff2_c = COEF_NEG_ONE;
  end

  // pipeline control
  logic a_valid, b_valid;
  logic a_ready, b_ready, out_ready;
  logic in_xfer, a_adv, b_adv;

  assign out_ready = !out_valid || !out_stall;
  assign b_ready   = !b_valid || out_ready;
  assign a_ready   = !a_valid || b_ready;
  assign in_stall  = !a_ready;
  assign in_xfer   = in_valid && a_ready;
  assign a_adv     = a_valid && b_ready;
  assign b_adv     = b_valid && out_ready;

  // input register
  logic signed [SAMPLE_WIDTH-1:0] a_sample;
  logic                           a_frame_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      a_sample    <= sample_in;
      a_frame_end <= frame_end;
    end
  end

  // state update stage
  logic signed [STATE_WIDTH-1:0] delay_one, delay_two;
  logic signed [PW-1:0]          prod_fb1, prod_fb2, prod_ff1, prod_ff2;
  logic signed [TW2-1:0]         tr_fb1, tr_fb2, tr_ff1, tr_ff2;
  logic signed [SUMW-1:0]        w_sum;
  logic signed [STATE_WIDTH-1:0] w_sat;
  logic                          w_hit;
  logic signed [TW2:0]           ff_sum;

  assign prod_fb1 = delay_one * fb1_c;
  assign prod_fb2 = delay_two * fb2_c;
  assign prod_ff1 = delay_one * ff1_c;
  assign prod_ff2 = delay_two * ff2_c;

  // dropping the low fraction bits floors toward minus infinity
  assign tr_fb1 = prod_fb1[PW-1:COEF_FRAC_BITS];
  assign tr_fb2 = prod_fb2[PW-1:COEF_FRAC_BITS];
  assign tr_ff1 = prod_ff1[PW-1:COEF_FRAC_BITS];
  assign tr_ff2 = prod_ff2[PW-1:COEF_FRAC_BITS];

  assign w_sum  = SUMW'(a_sample) + SUMW'(tr_fb1) + SUMW'(tr_fb2);
  assign ff_sum = (TW2+1)'(tr_ff1) + (TW2+1)'(tr_ff2);

  always_comb begin
    w_hit = 1'b0;
    w_sat = w_sum[STATE_WIDTH-1:0];
    if (w_sum > W_MAX) begin
      w_hit = 1'b1;
      w_sat = W_MAX[STATE_WIDTH-1:0];
    end else if (w_sum < W_MIN) begin
      w_hit = 1'b1;
      w_sat = W_MIN[STATE_WIDTH-1:0];
    end
  end

  logic signed [STATE_WIDTH-1:0] b_w;
  logic signed [TW2:0]           b_ff;
  logic                          b_hit;
  logic                          b_frame_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_one <= '0;
      delay_two <= '0;
      b_valid   <= 1'b0;
    end else begin
      if (a_adv) begin
        delay_one <= w_sat;
        delay_two <= delay_one;
      end
      if (b_ready) begin
        b_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      b_w         <= w_sat;
      b_ff        <= ff_sum;
      b_hit       <= w_hit;
      b_frame_end <= a_frame_end;
    end
  end

  // output stage
  logic signed [SUMW-1:0]         y_sum;
  logic signed [SAMPLE_WIDTH-1:0] y_sat;
  logic                           y_hit;

  assign y_sum = SUMW'(b_w) + SUMW'(b_ff);

  always_comb begin
    y_hit = 1'b0;
    y_sat = y_sum[SAMPLE_WIDTH-1:0];
    if (y_sum > Y_MAX) begin
      y_hit = 1'b1;
      y_sat = Y_MAX[SAMPLE_WIDTH-1:0];
    end else if (y_sum < Y_MIN) begin
      y_hit = 1'b1;
      y_sat = Y_MIN[SAMPLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      sample_out    <= y_sat;
      frame_end_out <= b_frame_end;
      saturated     <= b_hit || y_hit;
    end
  end

`ifndef NO_ASSERTIONS
  // delays shift by one on each state update
  a_delay_shift: assert property (@(posedge clk) disable iff (rst)
    a_adv |=> delay_two == $past(delay_one))
    else $error("delay_two did not take delay_one");

  // stored state is the clipped w handed to the next stage
  a_state_matches_stage: assert property (@(posedge clk) disable iff (rst)
    a_adv |=> delay_one == b_w)
    else $error("delay_one differs from w in flight");

  // empty pipeline never stalls the input
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    (!a_valid && !b_valid && !out_valid) |-> !in_stall)
    else $error("input stalled with empty pipeline");

  // a sample leaving the last stage lands in the output register
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    b_adv |=> out_valid)
    else $error("output register missed a sample");

  // reset empties every stage
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!a_valid && !b_valid && !out_valid))
    else $error("stage valid set after reset");
`endif

endmodule
